/* src/tapp_pkg.sv */
// ----------------------------------------------------------------------------
// tapp_pkg: shared types and constants for the three-axis pose PID unit
// Holds register indexes, reset values, the sequencer states and the
// serial multiplier handshake structs and the sat32 saturation function.
// ----------------------------------------------------------------------------
package tapp_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned LimWidth  = 31;
   localparam int unsigned CntWidth  = 5;

   localparam logic [2:0] CSR_KP        = 3'd0;
   localparam logic [2:0] CSR_KI        = 3'd1;
   localparam logic [2:0] CSR_KD_OVER_DT = 3'd2;
   localparam logic [2:0] CSR_PERIOD_DT = 3'd3;
   localparam logic [2:0] CSR_MAX_INT_LIN = 3'd4;
   localparam logic [2:0] CSR_MAX_INT_ANG = 3'd5;
   localparam logic [2:0] CSR_MAX_DEV_LIN = 3'd6;
   localparam logic [2:0] CSR_MAX_DEV_ANG = 3'd7;

   localparam logic [31:0] KP_RST        = 32'd300647710;
   localparam logic [31:0] KI_RST        = 32'd4294967;
   localparam logic [31:0] KD_RST        = 32'd4294967;
   localparam logic [31:0] DT_RST        = 32'd42949673;
   localparam logic [30:0] MAX_INT_LIN_RST = 31'd13107200;
   localparam logic [30:0] MAX_INT_ANG_RST = 31'd205887;
   localparam logic [30:0] MAX_DEV_LIN_RST = 31'd19660800;
   localparam logic [30:0] MAX_DEV_ANG_RST = 31'd205887;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERR,
      ST_MUL_I,
      ST_ACC,
      ST_MUL_P,
      ST_MUL_K,
      ST_MUL_D,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        start;
      logic [31:0] coef;
      logic signed [31:0] value;
   } mul_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic signed [31:0] result;
   } mul_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      logic signed [31:0] r;
      if (v > 35'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -35'sh0_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* src/tapp_serial_mul.sv */
// ----------------------------------------------------------------------------
// tapp_serial_mul: bit-serial Q0.32 by Q16.16 multiplier with rounding
// Scans the unsigned coefficient one bit per cycle, LSB first, adding the
// signed operand into a shifting partial sum; result rounded half up.
// ----------------------------------------------------------------------------
module tapp_serial_mul
   import tapp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   // acc holds the upper partial product; low bits shift out into lo
   logic signed [33:0] acc_ff, acc_in;
   logic [31:0]        lo_ff, lo_in;
   logic [31:0]        coef_ff, coef_in;
   logic signed [31:0] val_ff, val_in;
   logic [CntWidth:0]  cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic signed [31:0] res_ff, res_in;

   logic signed [33:0] sum;
   logic signed [33:0] rnd;

   always_comb begin
      acc_in  = acc_ff;
      lo_in   = lo_ff;
      coef_in = coef_ff;
      val_in  = val_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      sum = acc_ff + (coef_ff[0] ? {{2{val_ff[31]}}, val_ff} : 34'sd0);
      // product / 2^32 rounded: high part plus bit 31 of low part
      rnd = acc_ff + {33'd0, lo_ff[31]};
      if (req.start) begin
         acc_in  = '0;
         lo_in   = '0;
         coef_in = req.coef;
         val_in  = req.value;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == (CntWidth + 1)'(DataWidth)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = rnd[31:0];
         end else begin
            // arithmetic shift right one, bit falls into lo
            acc_in  = sum >>> 1;
            lo_in   = {sum[0], lo_ff[31:1]};
            coef_in = coef_ff >> 1;
            cnt_in  = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff  <= acc_in;
      lo_ff   <= lo_in;
      coef_ff <= coef_in;
      val_ff  <= val_in;
      res_ff  <= res_in;
   end

   assign rsp.busy   = busy_ff;
   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

endmodule

/* src/three_axis_pose_pid_unit.sv */
// ----------------------------------------------------------------------------
// three_axis_pose_pid_unit: PID controller on x, y and heading
// Each of the three axes runs an error step, a start step, four passes of
// the bit-serial multiplier and a write-back step. The input stalls while
// a transaction is in flight, so the next one is accepted only once idle.
// Output register frees the next transaction while a result waits; only a
// result still waiting when the next one finishes holds the unit.
// Synchronous reset loads register defaults, clears integrals and previous errors.
// ----------------------------------------------------------------------------
module three_axis_pose_pid_unit
   import tapp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_sp_x,
   input  logic signed [31:0] req_sp_y,
   input  logic signed [31:0] req_sp_heading,
   input  logic signed [31:0] req_cur_x,
   input  logic signed [31:0] req_cur_y,
   input  logic signed [31:0] req_cur_heading,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_corr_x,
   output logic signed [31:0] rsp_corr_y,
   output logic signed [31:0] rsp_corr_heading,
   output logic               rsp_deviation_warn,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   logic [31:0] kp_ff, ki_ff, kd_ff, dt_ff;
   logic [30:0] mil_ff, mia_ff, mdl_ff, mda_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff  <= KP_RST;
         ki_ff  <= KI_RST;
         kd_ff  <= KD_RST;
         dt_ff  <= DT_RST;
         mil_ff <= MAX_INT_LIN_RST;
         mia_ff <= MAX_INT_ANG_RST;
         mdl_ff <= MAX_DEV_LIN_RST;
         mda_ff <= MAX_DEV_ANG_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_KP:          kp_ff  <= csr_data;
            CSR_KI:          ki_ff  <= csr_data;
            CSR_KD_OVER_DT:  kd_ff  <= csr_data;
            CSR_PERIOD_DT:   dt_ff  <= csr_data;
            CSR_MAX_INT_LIN: mil_ff <= csr_data[30:0];
            CSR_MAX_INT_ANG: mia_ff <= csr_data[30:0];
            CSR_MAX_DEV_LIN: mdl_ff <= csr_data[30:0];
            CSR_MAX_DEV_ANG: mda_ff <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   state_type state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic signed [31:0] sp_ff [3];
   logic signed [31:0] cur_ff [3];
   logic signed [31:0] integ_ff [3];
   logic signed [31:0] prev_ff [3];
   logic signed [31:0] corr_ff [3];
   logic signed [31:0] out_x_ff, out_y_ff;
   logic               out_warn_ff;
   logic               warn_ff, warn_in;
   logic signed [31:0] e_ff, e_in, d_ff, d_in;
   logic signed [34:0] sum_ff, sum_in;
   logic               out_valid_ff, out_valid_in;
   logic               ld_in, integ_we, prev_we, corr_we, out_we;
   logic signed [31:0] integ_new;

   mul_req_type mreq;
   mul_rsp_type mrsp;

   tapp_serial_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .rsp   (mrsp)
   );

   logic signed [32:0] raw;
   logic [32:0]        mag;
   logic [30:0]        lim_dev, lim_int;
   logic signed [33:0] acc_sum;

   assign raw     = {sp_ff[axis_ff][31], sp_ff[axis_ff]} - {cur_ff[axis_ff][31], cur_ff[axis_ff]};
   assign mag     = raw[32] ? 33'(-raw) : 33'(raw);
   assign lim_dev = (axis_ff == 2'd2) ? mda_ff : mdl_ff;
   assign lim_int = (axis_ff == 2'd2) ? mia_ff : mil_ff;
   assign acc_sum = {{2{integ_ff[axis_ff][31]}}, integ_ff[axis_ff]}
                  + {{2{mrsp.result[31]}}, mrsp.result};

   always_comb begin
      if (acc_sum > $signed({3'b000, lim_int})) begin
         integ_new = {1'b0, lim_int};
      end else if (acc_sum < -$signed({3'b000, lim_int})) begin
         integ_new = -$signed({1'b0, lim_int});
      end else begin
         integ_new = acc_sum[31:0];
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      warn_in      = warn_ff;
      e_in         = e_ff;
      d_in         = d_ff;
      sum_in       = sum_ff;
      out_valid_in = out_valid_ff;
      ld_in        = 1'b0;
      integ_we     = 1'b0;
      prev_we      = 1'b0;
      corr_we      = 1'b0;
      out_we       = 1'b0;
      mreq.start   = 1'b0;
      mreq.coef    = dt_ff;
      mreq.value   = e_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               ld_in    = 1'b1;
               axis_in  = 2'd0;
               warn_in  = 1'b0;
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            if (mag > {2'b00, lim_dev}) begin
               warn_in = 1'b1;
            end
            e_in = sat32(35'(raw));
            // derivative uses the saturated error
            d_in = sat32(35'(sat32(35'(raw))) - 35'(prev_ff[axis_ff]));
            state_in = ST_MUL_I;
         end
         ST_MUL_I: begin
            mreq.start = 1'b1;
            mreq.coef  = dt_ff;
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            if (mrsp.done) begin
               integ_we   = 1'b1;
               prev_we    = 1'b1;
               mreq.start = 1'b1;
               mreq.coef  = kp_ff;
               mreq.value = e_ff;
               state_in   = ST_MUL_P;
            end
         end
         ST_MUL_P: begin
            if (mrsp.done) begin
               sum_in     = 35'(mrsp.result);
               mreq.start = 1'b1;
               mreq.coef  = ki_ff;
               mreq.value = integ_ff[axis_ff];
               state_in   = ST_MUL_K;
            end
         end
         ST_MUL_K: begin
            if (mrsp.done) begin
               sum_in     = sum_ff + 35'(mrsp.result);
               mreq.start = 1'b1;
               mreq.coef  = kd_ff;
               mreq.value = d_ff;
               state_in   = ST_MUL_D;
            end
         end
         ST_MUL_D: begin
            if (mrsp.done) begin
               sum_in   = sum_ff + 35'(mrsp.result);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (axis_ff != 2'd2) begin
               corr_we  = 1'b1;
               axis_in  = axis_ff + 1'b1;
               state_in = ST_ERR;
            end else if (!out_valid_ff || !rsp_stall) begin
               // hold here until the previous transaction leaves the output
               corr_we      = 1'b1;
               out_we       = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            integ_ff[i] <= '0;
            prev_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (integ_we) integ_ff[axis_ff] <= integ_new;
         if (prev_we)  prev_ff[axis_ff]  <= e_ff;
      end
      axis_ff <= axis_in;
      warn_ff <= warn_in;
      e_ff    <= e_in;
      d_ff    <= d_in;
      sum_ff  <= sum_in;
      if (ld_in) begin
         sp_ff[0]  <= req_sp_x;
         sp_ff[1]  <= req_sp_y;
         sp_ff[2]  <= req_sp_heading;
         cur_ff[0] <= req_cur_x;
         cur_ff[1] <= req_cur_y;
         cur_ff[2] <= req_cur_heading;
      end
      if (corr_we) corr_ff[axis_ff] <= sat32(sum_ff);
      if (out_we) begin
         out_x_ff    <= corr_ff[0];
         out_y_ff    <= corr_ff[1];
         out_warn_ff <= warn_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_corr_x         = out_x_ff;
   assign rsp_corr_y         = out_y_ff;
   assign rsp_corr_heading   = corr_ff[2];
   assign rsp_deviation_warn = out_warn_ff;

endmodule

/* src/tapp_checker.sv */
// ----------------------------------------------------------------------------
// tapp_checker: port-level checks for the pose PID unit
// Watches the two channels of the top level over time.
// ----------------------------------------------------------------------------
module tapp_checker
   import tapp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_corr_x,
   input logic        rsp_deviation_warn
);

   // one transaction in flight: input stalls right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after accept");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_corr_x)
                                    && $stable(rsp_deviation_warn)))
      else $error("stalled result changed");

   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown({rsp_corr_x, rsp_deviation_warn}))
      else $error("result has unknown bits");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind three_axis_pose_pid_unit tapp_checker u_tapp_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_corr_x         (rsp_corr_x),
   .rsp_deviation_warn (rsp_deviation_warn)
);
